>>> rtl/core/itp_pkg.sv
`default_nettype none

package itp_pkg;

  // Symbol width and default stack depth
  localparam int unsigned SymW          = 8;
  localparam int unsigned StackDepthDef = 32;

  // Symbol table
  localparam logic [SymW-1:0] SymMul   = 8'h2A;  // '*'
  localparam logic [SymW-1:0] SymDiv   = 8'h2F;  // '/'
  localparam logic [SymW-1:0] SymAdd   = 8'h2B;  // '+'
  localparam logic [SymW-1:0] SymSub   = 8'h2D;  // '-'
  localparam logic [SymW-1:0] SymOpen  = 8'h28;  // '('
  localparam logic [SymW-1:0] SymClose = 8'h29;  // ')'

  // Error codes
  localparam logic [1:0] ErrNone      = 2'd0;
  localparam logic [1:0] ErrOverflow  = 2'd1;
  localparam logic [1:0] ErrUnmatched = 2'd2;

  typedef enum logic [1:0] {
    CLS_OPERAND,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OPER
  } sym_cls_e;

  // One result item
  typedef struct packed {
    logic [SymW-1:0] sym;
    logic            has;
    logic            last;
    logic            eoe;
    logic [1:0]      err;
  } res_t;

  function automatic sym_cls_e sym_class(input logic [SymW-1:0] s);
    sym_cls_e c;
    c = CLS_OPERAND;
    if (s == SymOpen) begin
      c = CLS_OPEN;
    end else if (s == SymClose) begin
      c = CLS_CLOSE;
    end else if (s == SymMul || s == SymDiv || s == SymAdd || s == SymSub) begin
      c = CLS_OPER;
    end
    return c;
  endfunction

  // Precedence of a stacked entry or incoming operator (parentheses are 0)
  function automatic logic [1:0] prec(input logic [SymW-1:0] s);
    logic [1:0] p;
    p = 2'd0;
    if (s == SymMul || s == SymDiv) begin
      p = 2'd2;
    end else if (s == SymAdd || s == SymSub) begin
      p = 2'd1;
    end
    return p;
  endfunction

  function automatic res_t mk_res(input logic [SymW-1:0] sym, input logic has,
                                  input logic last, input logic eoe,
                                  input logic [1:0] err);
    res_t r;
    r.sym  = has ? sym : '0;
    r.has  = has;
    r.last = last;
    r.eoe  = eoe;
    r.err  = err;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/itp_stack_ram.sv
`default_nettype none

module itp_stack_ram #(
  parameter  int unsigned Depth = itp_pkg::StackDepthDef,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic                    clk_i,
  input  wire logic                    we_i,
  input  wire logic [AddrW-1:0]        waddr_i,
  input  wire logic [itp_pkg::SymW-1:0] wdata_i,
  input  wire logic                    re_i,
  input  wire logic [AddrW-1:0]        raddr_i,
  output logic      [itp_pkg::SymW-1:0] rdata_o
);
  import itp_pkg::*;

  logic [SymW-1:0] mem [Depth];
  logic [SymW-1:0] rdata_q;

  // Write one entry, register the read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/infix_to_postfix_converter_unit.sv
`default_nettype none
// Infix to postfix converter (shunting yard) with an operator stack in a
// synchronous single-port-read RAM.
// Input channel s_axis: one character per request in tdata, tuser high marks a
// flush (end of expression) and then tdata is ignored.
// Output channel m_axis: one postfix result per request. tdata carries the
// emitted character (zero for a status-only result), tlast marks the last
// result caused by one input request, tuser carries has_symbol, end of
// expression and the error code.
// Sequencing: an operand, a bare push or any item that meets an empty stack
// is handled when it is accepted, and its result, if any, is loaded into
// the output register. An operator, a close parenthesis or a flush on a
// non-empty stack moves to ST_EVAL, which examines stack entries through
// the registered RAM read, one entry per cycle while the output slot is
// free; an operator that empties the stack or a close parenthesis that finds
// no match then passes through ST_TAIL. Items are handled one at a time.
// Reset clears the stack count and the output register; the RAM contents are
// not cleared, since no entry is read before it was written.
// When the receiver stalls, the pending result holds in the output register
// and the sequencer halts until that request is taken.
module infix_to_postfix_converter_unit #(
  parameter int unsigned StackDepth = itp_pkg::StackDepthDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  wire logic [7:0]               s_axis_tdata_i,   // [7:0] symbol
  input  wire logic                     s_axis_tuser_i,   // [0] flush
  output logic                          m_axis_tvalid_o,
  input  wire logic                     m_axis_tready_i,
  output logic      [7:0]               m_axis_tdata_o,   // [7:0] out_symbol
  output logic                          m_axis_tlast_o,   // last_of_run
  output logic      [3:0]               m_axis_tuser_o    // [0] has_symbol,
                                                          // [1] end_of_expression,
                                                          // [3:2] error
);
  import itp_pkg::*;

  localparam int unsigned AddrW = $clog2(StackDepth);
  localparam int unsigned CntW  = $clog2(StackDepth + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EVAL = 3'b010,
    ST_TAIL = 3'b100
  } state_e;

  typedef enum logic [1:0] {
    MODE_FLUSH,
    MODE_CLOSE,
    MODE_OPER
  } mode_e;

  state_e            state_q, state_d;
  mode_e             mode_q, mode_d;
  logic [SymW-1:0]   op_q, op_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [SymW-1:0]   pend_q, pend_d;
  logic              pend_vld_q, pend_vld_d;
  logic [1:0]        tail_err_q, tail_err_d;
  res_t              out_q, out_d;
  logic              out_vld_q, out_vld_d;

  logic              ram_we, ram_re;
  logic [AddrW-1:0]  ram_waddr, ram_raddr;
  logic [SymW-1:0]   ram_wdata, top_sym;

  res_t              res;
  logic              res_vld;
  logic              slot_free, accept;
  logic [CntW-1:0]   cnt_m1, cnt_m2;
  logic              cnt_is_one, cnt_is_full, cnt_is_zero;
  sym_cls_e          in_cls;

  itp_stack_ram #(
    .Depth (StackDepth)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (top_sym)
  );

  assign slot_free       = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && slot_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign cnt_m1      = cnt_q - CntW'(1);
  assign cnt_m2      = cnt_q - CntW'(2);
  assign cnt_is_zero = (cnt_q == '0);
  assign cnt_is_one  = (cnt_q == CntW'(1));
  assign cnt_is_full = (cnt_q == CntW'(StackDepth));
  assign in_cls      = sym_class(s_axis_tdata_i);

  // Sequencer: read the top entry, decide, pop or push, emit
  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    op_d       = op_q;
    cnt_d      = cnt_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    tail_err_d = tail_err_q;
    ram_we     = 1'b0;
    ram_waddr  = cnt_q[AddrW-1:0];
    ram_wdata  = s_axis_tdata_i;
    ram_re     = 1'b0;
    ram_raddr  = cnt_m1[AddrW-1:0];
    res_vld    = 1'b0;
    res        = mk_res('0, 1'b0, 1'b0, 1'b0, ErrNone);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser_i) begin
            // Flush: empty stack gives a single status result
            if (cnt_is_zero) begin
              res_vld = 1'b1;
              res     = mk_res('0, 1'b0, 1'b1, 1'b1, ErrNone);
            end else begin
              ram_re  = 1'b1;
              mode_d  = MODE_FLUSH;
              state_d = ST_EVAL;
            end
          end else begin
            unique case (in_cls)
              CLS_OPERAND: begin
                res_vld = 1'b1;
                res     = mk_res(s_axis_tdata_i, 1'b1, 1'b1, 1'b0, ErrNone);
              end
              CLS_OPEN: begin
                if (cnt_is_full) begin
                  res_vld = 1'b1;
                  res     = mk_res('0, 1'b0, 1'b1, 1'b0, ErrOverflow);
                end else begin
                  ram_we = 1'b1;
                  cnt_d  = cnt_q + CntW'(1);
                end
              end
              CLS_CLOSE: begin
                if (cnt_is_zero) begin
                  res_vld = 1'b1;
                  res     = mk_res('0, 1'b0, 1'b1, 1'b0, ErrUnmatched);
                end else begin
                  ram_re  = 1'b1;
                  mode_d  = MODE_CLOSE;
                  state_d = ST_EVAL;
                end
              end
              CLS_OPER: begin
                if (cnt_is_zero) begin
                  ram_we = 1'b1;
                  cnt_d  = cnt_q + CntW'(1);
                end else begin
                  ram_re  = 1'b1;
                  op_d    = s_axis_tdata_i;
                  mode_d  = MODE_OPER;
                  state_d = ST_EVAL;
                end
              end
              default: ;
            endcase
          end
        end
      end

      ST_EVAL: begin
        if (slot_free) begin
          ram_raddr = cnt_m2[AddrW-1:0];
          unique case (mode_q)
            MODE_FLUSH: begin
              // Pop top first; the bottom entry closes the expression
              res_vld = 1'b1;
              res     = mk_res(top_sym, 1'b1, cnt_is_one, cnt_is_one, ErrNone);
              cnt_d   = cnt_m1;
              if (cnt_is_one) begin
                state_d = ST_IDLE;
              end else begin
                ram_re = 1'b1;
              end
            end
            MODE_CLOSE: begin
              cnt_d = cnt_m1;
              if (top_sym == SymOpen) begin
                // Drop the matching open parenthesis, release the held entry
                res_vld    = pend_vld_q;
                res        = mk_res(pend_q, 1'b1, 1'b1, 1'b0, ErrNone);
                pend_vld_d = 1'b0;
                state_d    = ST_IDLE;
              end else begin
                res_vld    = pend_vld_q;
                res        = mk_res(pend_q, 1'b1, 1'b0, 1'b0, ErrNone);
                pend_d     = top_sym;
                pend_vld_d = 1'b1;
                if (cnt_is_one) begin
                  tail_err_d = ErrUnmatched;
                  state_d    = ST_TAIL;
                end else begin
                  ram_re = 1'b1;
                end
              end
            end
            MODE_OPER: begin
              if (prec(top_sym) >= prec(op_q)) begin
                res_vld    = pend_vld_q;
                res        = mk_res(pend_q, 1'b1, 1'b0, 1'b0, ErrNone);
                pend_d     = top_sym;
                pend_vld_d = 1'b1;
                if (cnt_is_one) begin
                  // Stack ran empty: push into the freed bottom slot
                  ram_we     = 1'b1;
                  ram_waddr  = cnt_m1[AddrW-1:0];
                  ram_wdata  = op_q;
                  tail_err_d = ErrNone;
                  state_d    = ST_TAIL;
                end else begin
                  cnt_d  = cnt_m1;
                  ram_re = 1'b1;
                end
              end else begin
                // Lower precedence on top: push the operator, or flag overflow if full
                state_d = ST_IDLE;
                if (pend_vld_q) begin
                  ram_we     = 1'b1;
                  ram_wdata  = op_q;
                  cnt_d      = cnt_q + CntW'(1);
                  res_vld    = 1'b1;
                  res        = mk_res(pend_q, 1'b1, 1'b1, 1'b0, ErrNone);
                  pend_vld_d = 1'b0;
                end else if (cnt_is_full) begin
                  res_vld = 1'b1;
                  res     = mk_res('0, 1'b0, 1'b1, 1'b0, ErrOverflow);
                end else begin
                  ram_we    = 1'b1;
                  ram_wdata = op_q;
                  cnt_d     = cnt_q + CntW'(1);
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_TAIL: begin
        if (slot_free) begin
          res_vld = 1'b1;
          if (pend_vld_q) begin
            // Release the held entry; last only when no status follows
            res        = mk_res(pend_q, 1'b1, (tail_err_q == ErrNone), 1'b0, ErrNone);
            pend_vld_d = 1'b0;
            if (tail_err_q == ErrNone) begin
              state_d = ST_IDLE;
            end
          end else begin
            res     = mk_res('0, 1'b0, 1'b1, 1'b0, tail_err_q);
            state_d = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Output register: load on a new result, clear once taken
  always_comb begin
    out_d     = out_q;
    out_vld_d = out_vld_q;
    if (res_vld) begin
      out_d     = res;
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mode_q     <= MODE_FLUSH;
      cnt_q      <= '0;
      pend_vld_q <= 1'b0;
      tail_err_q <= ErrNone;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      cnt_q      <= cnt_d;
      pend_vld_q <= pend_vld_d;
      tail_err_q <= tail_err_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q.sym;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tuser_o  = {out_q.err, out_q.eoe, out_q.has};

endmodule

`default_nettype wire

>>> rtl/core/itp_checker.sv
`default_nettype none

module itp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid_i,
  input wire logic       s_axis_tready_o,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o,
  input wire logic       m_axis_tlast_o,
  input wire logic [3:0] m_axis_tuser_o
);
  import itp_pkg::*;

  // Hold a stalled result unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

  // A status-only result carries no character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == '0)
    else $error("status result with data");

  // End of expression closes the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> m_axis_tlast_o)
    else $error("end of expression without last");

  // An error is a status-only, final result with a known code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[3:2] != ErrNone) |->
      !m_axis_tuser_o[0] && m_axis_tlast_o && !m_axis_tuser_o[1]
      && (m_axis_tuser_o[3:2] == ErrOverflow || m_axis_tuser_o[3:2] == ErrUnmatched))
    else $error("malformed error result");

  // Take a request only when the output slot is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |-> !m_axis_tvalid_o || m_axis_tready_i)
    else $error("request taken while output stalled");

endmodule

bind infix_to_postfix_converter_unit itp_checker u_itp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
